// ===== rtl/heightmap_normal_unit_assert.svh =====
// Assertion macros for the height and normal lookup block.
`ifndef HEIGHTMAP_NORMAL_UNIT_ASSERT_SVH
`define HEIGHTMAP_NORMAL_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define HMN_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define HMN_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ## dly (cons)) \
        else $error(msg);
`else
`define HMN_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define HMN_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons, msg)
`endif
`endif

// ===== rtl/hmn_pkg.sv =====
package hmn_pkg;

    localparam int H_W       = 8;
    localparam int CO_W      = 9;
    localparam int MAG_W     = 9;
    localparam int S_W       = 19;
    localparam int Y_W       = 33;
    localparam int ROOT_W    = 17;
    localparam int COMP_W    = 16;
    localparam int DIV_STEPS = 32;
    localparam int NORM_LAT  = 2 + DIV_STEPS + ROOT_W + 1;
    localparam int NBR       = 5;

    // Neighbor slots of one lookup.
    localparam int P_C = 0;
    localparam int P_L = 1;
    localparam int P_R = 2;
    localparam int P_F = 3;
    localparam int P_B = 4;

    localparam logic [1:0] CFG_MAP_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_MAP_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_MAP_PRESENT = 2'd2;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [MAG_W-1:0]  UP_MAG  = 9'd510;
    localparam logic [S_W-1:0]    BASE_SQ = 19'd260100;
    localparam logic [ROOT_W-1:0] Q_MAX   = 17'd32767;
    localparam logic [COMP_W-1:0] FLAT_Y  = 16'd32767;

    typedef struct packed {
        logic           valid;
        logic           kind;
        logic           present;
        logic [H_W-1:0] data;
    } t_item_ctl;

    typedef struct packed {
        logic             valid;
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [S_W-1:0]   s;
    } t_norm_req;

endpackage

// ===== rtl/hmn_ram.sv =====
module hmn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/hmn_addr.sv =====
module hmn_addr #(
    parameter int MAX_DIM = 256
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  hmn_pkg::t_item_ctl                         i_ctl,
    input  logic [7:0]                                 i_row,
    input  logic [7:0]                                 i_col,
    input  logic [$clog2(MAX_DIM+1)-1:0]               i_width,
    input  logic [$clog2(MAX_DIM+1)-1:0]               i_height,
    output hmn_pkg::t_item_ctl                         o_ctl,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]         o_addr [hmn_pkg::NBR]
);
    import hmn_pkg::*;

    localparam int MD_W  = $clog2(MAX_DIM + 1);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int CMP_W = ((MD_W > 9) ? MD_W : 9) + 1;
    localparam int X_W   = CO_W + MD_W + 1;
    localparam int SH    = X_W + AW;
    localparam int RW    = X_W + 2;
    localparam logic [RW-1:0] RECIP =
        RW'(((64'd1 << SH) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));
    localparam logic [X_W-1:0] DEPTH_X = X_W'(DEPTH);
    localparam logic signed [CMP_W-1:0] ONE_S = CMP_W'(1);

    function automatic logic [CO_W-1:0] clamp_coord(
        input logic signed [CMP_W-1:0] v,
        input logic [MD_W-1:0]         dim
    );
        logic signed [CMP_W-1:0] lim;
        lim = signed'(CMP_W'(dim)) - ONE_S;
        if (v < 0) begin
            return '0;
        end else if (v > lim) begin
            return CO_W'(lim);
        end
        return CO_W'(v);
    endfunction

    logic signed [CMP_W-1:0] row_s;
    logic signed [CMP_W-1:0] col_s;
    logic [CO_W-1:0]         n_r [NBR];
    logic [CO_W-1:0]         n_c [NBR];

    always_comb begin
        row_s = signed'(CMP_W'(i_row));
        col_s = signed'(CMP_W'(i_col));
        n_r[P_L] = clamp_coord(row_s, i_height);
        n_c[P_L] = clamp_coord(col_s - ONE_S, i_width);
        n_r[P_R] = clamp_coord(row_s, i_height);
        n_c[P_R] = clamp_coord(col_s + ONE_S, i_width);
        n_r[P_F] = clamp_coord(row_s - ONE_S, i_height);
        n_c[P_F] = clamp_coord(col_s, i_width);
        n_r[P_B] = clamp_coord(row_s + ONE_S, i_height);
        n_c[P_B] = clamp_coord(col_s, i_width);
        // A write addresses the raw coordinates; it may spill into later rows.
        if (i_ctl.kind == KIND_WRITE) begin
            n_r[P_C] = CO_W'(i_row);
            n_c[P_C] = CO_W'(i_col);
        end else begin
            n_r[P_C] = clamp_coord(row_s, i_height);
            n_c[P_C] = clamp_coord(col_s, i_width);
        end
    end

    t_item_ctl       r_s1_ctl, r_s2_ctl, r_s3_ctl, r_s4_ctl;
    logic [CO_W-1:0] r_s1_r [NBR];
    logic [CO_W-1:0] r_s1_c [NBR];
    logic [X_W-1:0]  r_s2_x [NBR];
    logic [X_W-1:0]  r_s3_x0;
    logic [X_W-1:0]  r_s3_q;
    logic [AW-1:0]   r_s3_a [NBR];
    logic [AW-1:0]   r_s4_a [NBR];

    logic [X_W+RW-1:0] prod;
    logic [X_W-1:0]    n_rem;

    always_comb begin
        prod  = (X_W+RW)'(r_s2_x[P_C]) * (X_W+RW)'(RECIP);
        n_rem = r_s3_x0 - X_W'(r_s3_q * DEPTH_X);
        if (n_rem >= DEPTH_X) begin
            n_rem = n_rem - DEPTH_X;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl.valid <= 1'b0;
            r_s2_ctl.valid <= 1'b0;
            r_s3_ctl.valid <= 1'b0;
            r_s4_ctl.valid <= 1'b0;
        end else begin
            r_s1_ctl <= i_ctl;
            r_s2_ctl <= r_s1_ctl;
            r_s3_ctl <= r_s2_ctl;
            r_s4_ctl <= r_s3_ctl;
        end
        for (int p = 0; p < NBR; p++) begin
            r_s1_r[p] <= n_r[p];
            r_s1_c[p] <= n_c[p];
            r_s2_x[p] <= X_W'(r_s1_r[p]) * X_W'(i_width) + X_W'(r_s1_c[p]);
            r_s3_a[p] <= AW'(r_s2_x[p]);
            // The center address wraps modulo the store depth.
            r_s4_a[p] <= (p == P_C) ? AW'(n_rem) : r_s3_a[p];
        end
        r_s3_x0 <= r_s2_x[P_C];
        r_s3_q  <= X_W'(prod >> SH);
    end

    assign o_ctl  = r_s4_ctl;
    assign o_addr = r_s4_a;
endmodule

// ===== rtl/hmn_norm.sv =====
module hmn_norm (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  hmn_pkg::t_norm_req                 i_req,
    output logic                               o_valid,
    output logic signed [hmn_pkg::COMP_W-1:0]  o_comp
);
    import hmn_pkg::*;

    localparam int RM_W = Y_W + 2;

    // Stage A: square of the component magnitude.
    logic             r_va;
    logic             r_nega;
    logic [S_W-1:0]   r_sa;
    logic [S_W-1:0]   r_sqa;
    logic [2*MAG_W-1:0] sq_full;

    assign sq_full = i_req.mag * i_req.mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else begin
            r_va <= i_req.valid;
        end
        r_nega <= i_req.neg;
        r_sa   <= i_req.s;
        r_sqa  <= S_W'(sq_full);
    end

    // Restoring division: Y = floor(mag^2 * 2^32 / s), one quotient bit a stage.
    logic           r_dv   [DIV_STEPS+1];
    logic           r_dneg [DIV_STEPS+1];
    logic [S_W-1:0] r_ds   [DIV_STEPS+1];
    logic [S_W-1:0] r_drem [DIV_STEPS+1];
    logic [Y_W-1:0] r_dquo [DIV_STEPS+1];

    logic init_ge;
    assign init_ge = (r_sqa >= r_sa);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else begin
            r_dv[0] <= r_va;
        end
        r_dneg[0] <= r_nega;
        r_ds[0]   <= r_sa;
        r_drem[0] <= init_ge ? (r_sqa - r_sa) : r_sqa;
        r_dquo[0] <= Y_W'(init_ge);
    end

    for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_div
        logic [S_W:0] dbl;
        logic         ge;
        assign dbl = {r_drem[i-1], 1'b0};
        assign ge  = (dbl >= {1'b0, r_ds[i-1]});
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[i] <= 1'b0;
            end else begin
                r_dv[i] <= r_dv[i-1];
            end
            r_dneg[i] <= r_dneg[i-1];
            r_ds[i]   <= r_ds[i-1];
            r_drem[i] <= ge ? S_W'(dbl - {1'b0, r_ds[i-1]}) : S_W'(dbl);
            r_dquo[i] <= {r_dquo[i-1][Y_W-2:0], ge};
        end
    end

    // Square root of Y, one root bit a stage, keeping Y - root^2.
    logic              r_qv    [ROOT_W];
    logic              r_qneg  [ROOT_W];
    logic [RM_W-1:0]   r_qrem  [ROOT_W];
    logic [ROOT_W-1:0] r_qroot [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
        localparam int B = ROOT_W - 1 - j;
        logic              p_v;
        logic              p_neg;
        logic [RM_W-1:0]   p_rem;
        logic [ROOT_W-1:0] p_root;
        logic [RM_W-1:0]   delta;
        logic              ge;
        if (j == 0) begin : g_first
            assign p_v    = r_dv[DIV_STEPS];
            assign p_neg  = r_dneg[DIV_STEPS];
            assign p_rem  = RM_W'(r_dquo[DIV_STEPS]);
            assign p_root = '0;
        end else begin : g_next
            assign p_v    = r_qv[j-1];
            assign p_neg  = r_qneg[j-1];
            assign p_rem  = r_qrem[j-1];
            assign p_root = r_qroot[j-1];
        end
        assign delta = (RM_W'(p_root) << (B + 1)) + (RM_W'(1) << (2 * B));
        assign ge    = (p_rem >= delta);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_qv[j] <= 1'b0;
            end else begin
                r_qv[j] <= p_v;
            end
            r_qneg[j]  <= p_neg;
            r_qrem[j]  <= ge ? (p_rem - delta) : p_rem;
            r_qroot[j] <= ge ? (p_root | (ROOT_W'(1) << B)) : p_root;
        end
    end

    // Largest q with (2q-1)^2 <= Y is (root+1)/2; saturate and apply the sign.
    logic [ROOT_W:0]   sum;
    logic [ROOT_W-1:0] lo;
    logic [COMP_W-1:0] pos;
    logic [COMP_W-1:0] n_comp;
    logic              r_valid;
    logic [COMP_W-1:0] r_comp;

    always_comb begin
        sum = (ROOT_W+1)'(r_qroot[ROOT_W-1]) + (ROOT_W+1)'(1);
        lo  = sum[ROOT_W:1];
        pos = (lo > Q_MAX) ? COMP_W'(Q_MAX) : COMP_W'(lo);
        n_comp = r_qneg[ROOT_W-1] ? (COMP_W'(0) - pos) : pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_qv[ROOT_W-1];
        end
        r_comp <= n_comp;
    end

    assign o_valid = r_valid;
    assign o_comp  = signed'(r_comp);
endmodule

// ===== rtl/heightmap_normal_unit.sv =====
// Channel   Dir  Signals                                     Handshake
// request   in   i_kind, i_row, i_col, i_height_in           start high, busy low
// result    out  o_height_out, o_normal_x/_y/_z              o_valid, one cycle
// config    in   i_cfg_idx, i_cfg_data                       i_cfg_we, no wait
//
// A request is taken every cycle; busy is never raised.
// A query passes the address stages, the store read, the difference stage and
// the divider and 17-stage square root of each normal lane. A write request
// produces no result and lands in the store after the address stages. Reset
// is synchronous, active low, and clears the pipeline valid bits and the config
// registers. Results cannot be held off; each shows on o_valid for one cycle.
`include "heightmap_normal_unit_assert.svh"

module heightmap_normal_unit #(
    parameter int MAX_DIM = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_kind,
    input  logic [7:0]         i_row,
    input  logic [7:0]         i_col,
    input  logic [7:0]         i_height_in,
    output logic               o_valid,
    output logic [7:0]         o_height_out,
    output logic signed [15:0] o_normal_x,
    output logic signed [15:0] o_normal_y,
    output logic signed [15:0] o_normal_z,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [8:0]         i_cfg_data
);
    import hmn_pkg::*;

    localparam int MD_W  = $clog2(MAX_DIM + 1);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = (MD_W > 9) ? MD_W : 9;
    localparam int LAT   = 7 + NORM_LAT;

    // The block never refuses a request.
    assign busy = 1'b0;

    // Configuration registers. The user changes them only while nothing is in flight; the block does not enforce it.
    logic [8:0] r_map_width;
    logic [8:0] r_map_height;
    logic       r_map_present;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width   <= 9'd256;
            r_map_height  <= 9'd256;
            r_map_present <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAP_WIDTH:   r_map_width   <= i_cfg_data;
                CFG_MAP_HEIGHT:  r_map_height  <= i_cfg_data;
                CFG_MAP_PRESENT: r_map_present <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // A size of zero acts as one, and a size beyond the store acts as its edge.
    function automatic logic [MD_W-1:0] eff_dim(input logic [8:0] v);
        if (v == 9'd0) begin
            return MD_W'(1);
        end else if (CW'(v) > CW'(MAX_DIM)) begin
            return MD_W'(MAX_DIM);
        end
        return MD_W'(v);
    endfunction

    logic [MD_W-1:0] eff_width;
    logic [MD_W-1:0] eff_height;
    assign eff_width  = eff_dim(r_map_width);
    assign eff_height = eff_dim(r_map_height);

    // Stages 1 to 4: clamp the five sample coordinates (a write's center stays raw) and form the addresses.
    t_item_ctl in_ctl;
    t_item_ctl addr_ctl;
    logic [AW-1:0] addr [NBR];

    always_comb begin
        in_ctl.valid   = start && !busy;
        in_ctl.kind    = i_kind;
        in_ctl.present = r_map_present;
        in_ctl.data    = i_height_in;
    end

    hmn_addr #(
        .MAX_DIM (MAX_DIM)
    ) u_addr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (in_ctl),
        .i_row    (i_row),
        .i_col    (i_col),
        .i_width  (eff_width),
        .i_height (eff_height),
        .o_ctl    (addr_ctl),
        .o_addr   (addr)
    );

    // Five copies of the store, written together, so that the center and all
    // four neighbors are read in the same cycle. Writes and reads pass the same
    // stage, so a query always sees every write taken before it.
    logic          ram_we;
    logic [H_W-1:0] rdata [NBR];

    assign ram_we = addr_ctl.valid && (addr_ctl.kind == KIND_WRITE);

    for (genvar p = 0; p < NBR; p++) begin : g_bank
        hmn_ram #(
            .WIDTH (H_W),
            .DEPTH (DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (ram_we),
            .i_waddr (addr[P_C]),
            .i_wdata (addr_ctl.data),
            .i_raddr (addr[p]),
            .o_rdata (rdata[p])
        );
    end

    // Stage 5 lines up with the registered read data.
    t_item_ctl r_s5_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_ctl.valid <= 1'b0;
        end else begin
            r_s5_ctl <= addr_ctl;
        end
    end

    // Stage 6: central differences, their magnitudes and squares.
    logic signed [MAG_W-1:0] diff_x;
    logic signed [MAG_W-1:0] diff_z;
    logic [MAG_W-1:0]        n_magx;
    logic [MAG_W-1:0]        n_magz;

    always_comb begin
        diff_x = signed'({1'b0, rdata[P_L]}) - signed'({1'b0, rdata[P_R]});
        diff_z = signed'({1'b0, rdata[P_F]}) - signed'({1'b0, rdata[P_B]});
        n_magx = diff_x[MAG_W-1] ? MAG_W'(-diff_x) : MAG_W'(diff_x);
        n_magz = diff_z[MAG_W-1] ? MAG_W'(-diff_z) : MAG_W'(diff_z);
    end

    t_item_ctl          r_s6_ctl;
    logic [H_W-1:0]     r_s6_h;
    logic [MAG_W-1:0]   r_s6_magx;
    logic [MAG_W-1:0]   r_s6_magz;
    logic               r_s6_negx;
    logic               r_s6_negz;
    logic [2*MAG_W-1:0] r_s6_sqx;
    logic [2*MAG_W-1:0] r_s6_sqz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_ctl.valid <= 1'b0;
        end else begin
            r_s6_ctl <= r_s5_ctl;
        end
        r_s6_h    <= rdata[P_C];
        r_s6_magx <= n_magx;
        r_s6_magz <= n_magz;
        r_s6_negx <= diff_x[MAG_W-1];
        r_s6_negz <= diff_z[MAG_W-1];
        r_s6_sqx  <= n_magx * n_magx;
        r_s6_sqz  <= n_magz * n_magz;
    end

    // Squared length of (dx, 510, dz) feeds three normalizing lanes.
    logic [S_W-1:0] len_sq;
    logic           lane_valid;
    t_norm_req      req_x, req_y, req_z;

    always_comb begin
        len_sq     = S_W'(r_s6_sqx) + S_W'(r_s6_sqz) + BASE_SQ;
        lane_valid = r_s6_ctl.valid && (r_s6_ctl.kind == KIND_QUERY);
        req_x = '{valid: lane_valid, neg: r_s6_negx, mag: r_s6_magx, s: len_sq};
        req_y = '{valid: lane_valid, neg: 1'b0,      mag: UP_MAG,    s: len_sq};
        req_z = '{valid: lane_valid, neg: r_s6_negz, mag: r_s6_magz, s: len_sq};
    end

    logic                     vx, vy, vz;
    logic signed [COMP_W-1:0] cx, cy, cz;

    hmn_norm u_norm_x (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_x),
                       .o_valid(vx), .o_comp(cx));
    hmn_norm u_norm_y (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_y),
                       .o_valid(vy), .o_comp(cy));
    hmn_norm u_norm_z (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_z),
                       .o_valid(vz), .o_comp(cz));

    // The center height and the map-present flag ride alongside the lanes.
    logic [H_W:0] r_dly [NORM_LAT];

    always_ff @(posedge i_clk) begin
        r_dly[0] <= {r_s6_ctl.present, r_s6_h};
        for (int i = 1; i < NORM_LAT; i++) begin
            r_dly[i] <= r_dly[i-1];
        end
    end

    // Output register. With no map loaded the answer is flat ground.
    logic               r_valid;
    logic [H_W-1:0]     r_height;
    logic [COMP_W-1:0]  r_nx, r_ny, r_nz;
    logic               out_present;

    assign out_present = r_dly[NORM_LAT-1][H_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= vx && vy && vz;
        end
        if (out_present) begin
            r_height <= r_dly[NORM_LAT-1][H_W-1:0];
            r_nx     <= unsigned'(cx);
            r_ny     <= unsigned'(cy);
            r_nz     <= unsigned'(cz);
        end else begin
            r_height <= '0;
            r_nx     <= '0;
            r_ny     <= FLAT_Y;
            r_nz     <= '0;
        end
    end

    assign o_valid      = r_valid;
    assign o_height_out = r_height;
    assign o_normal_x   = signed'(r_nx);
    assign o_normal_y   = signed'(r_ny);
    assign o_normal_z   = signed'(r_nz);

    // A query always answers after the fixed latency, a write never does, and
    // the up component of any answer is positive.
    `HMN_ASSERT_DELAY(a_query_answers, i_clk, i_rst_n, start && !busy && i_kind == KIND_QUERY, LAT, o_valid, "query produced no result")
    `HMN_ASSERT_DELAY(a_write_silent, i_clk, i_rst_n, start && !busy && i_kind == KIND_WRITE, LAT, !o_valid, "write produced a result")
    `HMN_ASSERT_IMPL(a_up_positive, i_clk, i_rst_n, o_valid, o_normal_y > 0, "normal y not positive")
endmodule

// ===== verif/tb_heightmap_normal_unit.sv =====
// Testbench for heightmap_normal_unit.
//
// The map is set up in several phases. Each phase writes the size and presence
// registers while the block is idle, fills every sample inside the map, and
// then sends a mix of query and write requests. Queries only ever look up
// entries inside the filled map, because the block clamps every coordinate
// into it. A scoreboard object keeps its own copy of the height store and the
// registers, works out the height and Q1.15 normal of each query as it is
// accepted, and compares each result strobe against the oldest expectation.
module tb_heightmap_normal_unit;
    import hmn_pkg::*;

    localparam int CLK_HALF  = 6;
    localparam int DEPTH     = 65536;
    localparam int DRAIN_LIM = 200000;
    // The tail wait outlasts the block's path from request to result.
    localparam int TAIL_CYC  = 80;

    typedef struct {
        logic [7:0]         height;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
    } normal_result_t;

    // Predicts the block from its own store and register copies.
    class normal_scoreboard;
        logic [7:0]     heights[DEPTH];
        logic [8:0]     width_reg;
        logic [8:0]     height_reg;
        logic           present;
        normal_result_t pending[$];
        int             errors;

        function new();
            width_reg  = 9'd256;
            height_reg = 9'd256;
            present    = 1'b0;
            errors     = 0;
            foreach (heights[i]) heights[i] = 8'd0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [8:0] data);
            if (idx == CFG_MAP_WIDTH) width_reg = data;
            else if (idx == CFG_MAP_HEIGHT) height_reg = data;
            else if (idx == CFG_MAP_PRESENT) present = data[0];
        endfunction

        // Zero behaves as one and anything above 256 as 256.
        function int eff_dim(logic [8:0] v);
            if (v == 0) return 1;
            if (v > 256) return 256;
            return int'(v);
        endfunction

        function int sample(int r, int c);
            int w;
            int h;
            w = eff_dim(width_reg);
            h = eff_dim(height_reg);
            if (r < 0) r = 0;
            if (r > h - 1) r = h - 1;
            if (c < 0) c = 0;
            if (c > w - 1) c = w - 1;
            return int'(heights[(r * w + c) % DEPTH]);
        endfunction

        // Largest q with (2q-1)^2 * s <= 4 * c^2 * 2^30, which is c/sqrt(s)
        // in Q1.15 rounded half away from zero; saturated, then signed.
        function logic [15:0] unit_comp(int c, longint unsigned s);
            longint unsigned mag;
            longint unsigned rhs;
            longint unsigned t;
            int unsigned     lo;
            int unsigned     hi;
            int unsigned     mid;
            int              q;
            mag = longint'((c < 0) ? -c : c);
            rhs = (mag * mag) << 32;
            lo  = 0;
            hi  = 32768;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                t   = 2 * longint'(mid) - 1;
                if (t * t * s <= rhs) lo = mid;
                else hi = mid - 1;
            end
            q = (lo > 32767) ? 32767 : int'(lo);
            if (c < 0) q = -q;
            return q[15:0];
        endfunction

        function void note_request(logic kind, logic [7:0] row, logic [7:0] col,
                                   logic [7:0] hin);
            normal_result_t  e;
            int              r;
            int              c;
            int              dx;
            int              dz;
            longint unsigned s;
            r = int'(row);
            c = int'(col);
            if (kind == KIND_WRITE) begin
                heights[(r * eff_dim(width_reg) + c) % DEPTH] = hin;
                return;
            end
            if (!present) begin
                e.height = 8'd0;
                e.nx     = 16'sd0;
                e.ny     = 16'sd32767;
                e.nz     = 16'sd0;
            end else begin
                dx = sample(r, c - 1) - sample(r, c + 1);
                dz = sample(r - 1, c) - sample(r + 1, c);
                s  = longint'(dx * dx) + 260100 + longint'(dz * dz);
                e.height = 8'(sample(r, c));
                e.nx     = unit_comp(dx, s);
                e.ny     = unit_comp(510, s);
                e.nz     = unit_comp(dz, s);
            end
            pending.push_back(e);
        endfunction

        function void check_result(logic [7:0] height, logic [15:0] nx,
                                   logic [15:0] ny, logic [15:0] nz);
            normal_result_t e;
            if (pending.size() == 0) begin
                $error("result strobe with no query outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (height !== e.height) begin
                $error("height_out: expected %0d, got %0d", e.height, height);
                errors++;
            end
            if (nx !== e.nx) begin
                $error("normal_x: expected %0d, got %0d", e.nx, $signed(nx));
                errors++;
            end
            if (ny !== e.ny) begin
                $error("normal_y: expected %0d, got %0d", e.ny, $signed(ny));
                errors++;
            end
            if (nz !== e.nz) begin
                $error("normal_z: expected %0d, got %0d", e.nz, $signed(nz));
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_kind;
    logic [7:0]         i_row;
    logic [7:0]         i_col;
    logic [7:0]         i_height_in;
    logic               o_valid;
    logic [7:0]         o_height_out;
    logic signed [15:0] o_normal_x;
    logic signed [15:0] o_normal_y;
    logic signed [15:0] o_normal_z;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [8:0]         i_cfg_data;

    normal_scoreboard sb;
    int               burst_left;

    heightmap_normal_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_kind      (i_kind),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_height_in (i_height_in),
        .o_valid     (o_valid),
        .o_height_out(o_height_out),
        .o_normal_x  (o_normal_x),
        .o_normal_y  (o_normal_y),
        .o_normal_z  (o_normal_z),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // Requests and results are both sampled at the edge, before any
    // nonblocking update of that edge lands.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            sb.note_request(i_kind, i_row, i_col, i_height_in);
        end
        if (i_rst_n && o_valid) begin
            sb.check_result(o_height_out, o_normal_x, o_normal_y, o_normal_z);
        end
    end

    // Drives one request and holds it until the block takes it. Between
    // bursts of random length the sender drops start for a random gap.
    task automatic send_request(logic kind, logic [7:0] row, logic [7:0] col,
                                logic [7:0] hin);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        start       <= 1'b1;
        i_kind      <= kind;
        i_row       <= row;
        i_col       <= col;
        i_height_in <= hin;
        do @(posedge i_clk); while (busy);
        burst_left--;
    endtask

    // Lets every outstanding query come back, then waits out the pipeline so
    // that writes have landed as well.
    task automatic drain();
        int waited;
        start <= 1'b0;
        burst_left = 0;
        waited = 0;
        while (sb.pending.size() != 0 && waited < DRAIN_LIM) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [8:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    // Sets up a new map and writes every sample inside it.
    task automatic begin_phase(logic [8:0] w, logic [8:0] h, logic pres);
        int ew;
        int eh;
        drain();
        write_reg(CFG_MAP_WIDTH, w);
        write_reg(CFG_MAP_HEIGHT, h);
        write_reg(CFG_MAP_PRESENT, {8'd0, pres});
        @(posedge i_clk);
        ew = sb.eff_dim(w);
        eh = sb.eff_dim(h);
        for (int r = 0; r < eh; r++) begin
            for (int c = 0; c < ew; c++) begin
                send_request(KIND_WRITE, r[7:0], c[7:0], 8'($urandom));
            end
        end
    endtask

    // Mostly queries anywhere, since clamping keeps them inside the filled
    // map; the rest are writes that may run past the width into later rows.
    task automatic random_traffic(int n);
        int eh;
        eh = sb.eff_dim(sb.height_reg);
        repeat (n) begin
            if ($urandom_range(0, 3) != 0) begin
                send_request(KIND_QUERY, 8'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                send_request(KIND_WRITE, 8'($urandom_range(0, eh - 1)), 8'($urandom),
                             8'($urandom));
            end
        end
    endtask

    initial begin
        #(CLK_HALF * 2 * 3000000);
        $display("status: fail");
        $finish;
    end

    initial begin
        sb = new();
        burst_left  = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_kind      = KIND_WRITE;
        i_row       = 8'd0;
        i_col       = 8'd0;
        i_height_in = 8'd0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_MAP_WIDTH;
        i_cfg_data  = 9'd0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // No map after reset: queries at the corners give flat answers, and
        // writes still reach the store.
        send_request(KIND_QUERY, 8'd0, 8'd0, 8'd0);
        send_request(KIND_QUERY, 8'd255, 8'd255, 8'd255);
        send_request(KIND_WRITE, 8'd255, 8'd255, 8'd255);
        send_request(KIND_QUERY, 8'd0, 8'd255, 8'd0);

        // A single sample: all differences vanish, so the up component has
        // length exactly one and must saturate.
        begin_phase(9'd1, 9'd1, 1'b1);
        send_request(KIND_QUERY, 8'd0, 8'd0, 8'd0);
        send_request(KIND_QUERY, 8'd255, 8'd255, 8'd0);

        // A 3x3 map with the steepest slopes in both directions, then the
        // opposite signs.
        begin_phase(9'd3, 9'd3, 1'b1);
        send_request(KIND_WRITE, 8'd1, 8'd0, 8'd255);
        send_request(KIND_WRITE, 8'd1, 8'd2, 8'd0);
        send_request(KIND_WRITE, 8'd0, 8'd1, 8'd0);
        send_request(KIND_WRITE, 8'd2, 8'd1, 8'd255);
        send_request(KIND_QUERY, 8'd1, 8'd1, 8'd0);
        send_request(KIND_WRITE, 8'd1, 8'd0, 8'd0);
        send_request(KIND_WRITE, 8'd1, 8'd2, 8'd255);
        send_request(KIND_WRITE, 8'd0, 8'd1, 8'd255);
        send_request(KIND_WRITE, 8'd2, 8'd1, 8'd0);
        send_request(KIND_QUERY, 8'd1, 8'd1, 8'd0);
        // Write with a column past the width lands in a later row.
        send_request(KIND_WRITE, 8'd0, 8'd4, 8'd200);
        send_request(KIND_QUERY, 8'd0, 8'd0, 8'd0);
        send_request(KIND_QUERY, 8'd255, 8'd0, 8'd0);
        send_request(KIND_QUERY, 8'd0, 8'd255, 8'd0);
        random_traffic(50);

        // Sizes of zero act as one.
        begin_phase(9'd0, 9'd0, 1'b1);
        random_traffic(20);

        begin_phase(9'd7, 9'd5, 1'b1);
        random_traffic(50);

        // A width above the limit acts as the widest map of 256 columns.
        begin_phase(9'd511, 9'd1, 1'b1);
        random_traffic(40);

        // Map switched off again with a store full of data.
        begin_phase(9'd4, 9'd3, 1'b0);
        random_traffic(20);

        begin_phase(9'd6, 9'd4, 1'b1);
        random_traffic(40);

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            if (sb.pending.size() != 0) begin
                $error("%0d query results never arrived", sb.pending.size());
            end
            $display("status: fail");
        end
        $finish;
    end

endmodule
